FILE: rtl/hsvr_pkg.sv
// hsvr_pkg: widths, reciprocal constants and helpers for the hsv to rgb pipeline
// used by hsvr_datapath and hsv_to_rgb_permille; no dependencies
`timescale 1ns / 1ps

package hsvr_pkg;

   localparam int IN_W    = 16;
   localparam int LEVEL_W = 10;
   localparam int SECT_W  = 3;
   localparam int WITHIN_W = 6;

   localparam logic [LEVEL_W-1:0] UNIT_MAX   = 10'd1000;
   localparam logic [6:0]         SECTOR_DEG = 7'd60;

   // floor(n / 60) = (n * RECIP60) >> RECIP60_SH, exact for n < 2**16
   localparam logic [17:0] RECIP60    = 18'd139811;
   localparam int          RECIP60_SH = 23;
   // floor(n / 1000) = (n * RECIP1000) >> RECIP1000_SH, exact for n <= 10**6
   localparam logic [20:0] RECIP1000    = 21'd1073742;
   localparam int          RECIP1000_SH = 30;
   // floor(n / 6) = (n * RECIP6) >> RECIP6_SH, exact for n < 2**11
   localparam logic [10:0] RECIP6    = 11'd1366;
   localparam int          RECIP6_SH = 13;

   localparam logic [SECT_W-1:0] SECT_RED_GRN = 3'd0;
   localparam logic [SECT_W-1:0] SECT_GRN_RED = 3'd1;
   localparam logic [SECT_W-1:0] SECT_GRN_BLU = 3'd2;
   localparam logic [SECT_W-1:0] SECT_BLU_GRN = 3'd3;
   localparam logic [SECT_W-1:0] SECT_BLU_RED = 3'd4;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } rgb_type;

   function automatic logic [LEVEL_W-1:0] clamp_in(input logic [IN_W-1:0] v);
      clamp_in = (v > IN_W'(UNIT_MAX)) ? UNIT_MAX : v[LEVEL_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] clamp_sum(input logic [LEVEL_W:0] v);
      clamp_sum = (v > {1'b0, UNIT_MAX}) ? UNIT_MAX : v[LEVEL_W-1:0];
   endfunction

endpackage

FILE: rtl/hsv_to_rgb_permille.sv
// hsv_to_rgb_permille: converts hue, saturation and value to rgb levels
// depends on hsvr_pkg and hsvr_datapath
// throughput one item per cycle while no result waits under rsp_stall
// the five-stage datapath holds as a whole while a result waits under rsp_stall
// reset: synchronous, active high, clears all stage valid bits; data registers are not reset
`timescale 1ns / 1ps

module hsv_to_rgb_permille (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_hue_degrees,
   input  logic [15:0] req_sat_permille,
   input  logic [15:0] req_val_permille,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_red_level,
   output logic [9:0]  rsp_green_level,
   output logic [9:0]  rsp_blue_level
);

   logic              pipe_en;
   hsvr_pkg::rgb_type rgb;

   // the pipe moves unless the output register holds an untaken result
   assign pipe_en   = !rsp_valid || !rsp_stall;
   assign req_stall = !pipe_en;

   hsvr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_valid  (req_valid),
      .hue       (req_hue_degrees),
      .sat       (req_sat_permille),
      .val       (req_val_permille),
      .out_valid (rsp_valid),
      .out_rgb   (rgb)
   );

   assign rsp_red_level   = rgb.red;
   assign rsp_green_level = rgb.green;
   assign rsp_blue_level  = rgb.blue;

endmodule

FILE: rtl/hsvr_datapath.sv
// hsvr_datapath: five-stage hsv to rgb datapath with valid bits per stage
// depends on hsvr_pkg; advances all stages together on enable
`timescale 1ns / 1ps

module hsvr_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [hsvr_pkg::IN_W-1:0]    hue,
   input  logic [hsvr_pkg::IN_W-1:0]    sat,
   input  logic [hsvr_pkg::IN_W-1:0]    val,
   output logic                         out_valid,
   output hsvr_pkg::rgb_type            out_rgb
);

   localparam int LW = hsvr_pkg::LEVEL_W;

   logic [4:0] valid_ff, valid_in;

   // stage 1: clamp, hue / 60, value * saturation
   logic [hsvr_pkg::IN_W-1:0] s1_hue_ff;
   logic [10:0]               s1_q60_ff, s1_q60_in;
   logic [LW-1:0]             s1_val_ff, s1_val_in, s1_sat_in;
   logic [19:0]               s1_vs_ff, s1_vs_in;
   logic [33:0]               s1_q60_prod;

   // stage 2: within sector, q60 / 6, chroma
   logic [hsvr_pkg::WITHIN_W-1:0] s2_within_ff, s2_within_in;
   logic [10:0]                   s2_q60_ff;
   logic [7:0]                    s2_q6_ff, s2_q6_in;
   logic [LW-1:0]                 s2_chroma_ff, s2_chroma_in, s2_val_ff;
   logic [40:0]                   s2_chroma_prod;
   logic [21:0]                   s2_q6_prod;
   logic [15:0]                   s2_q60_x60;

   // stage 3: sector, chroma * distance, offset
   logic [hsvr_pkg::SECT_W-1:0] s3_sector_ff, s3_sector_in;
   logic [15:0]                 s3_cd_ff, s3_cd_in;
   logic [LW-1:0]               s3_chroma_ff, s3_offset_ff, s3_offset_in;
   logic [10:0]                 s3_q6_x6;
   logic [6:0]                  s3_dist;

   // stage 4: secondary component
   logic [hsvr_pkg::SECT_W-1:0] s4_sector_ff;
   logic [LW-1:0]               s4_chroma_ff, s4_offset_ff, s4_second_ff, s4_second_in;
   logic [33:0]                 s4_second_prod;

   // stage 5: channel select, offset add, clamp
   hsvr_pkg::rgb_type s5_rgb_ff, s5_rgb_in;
   logic [LW-1:0]     r_sel, g_sel, b_sel;

   always_comb begin
      valid_in = {valid_ff[3:0], in_valid};
   end

   always_comb begin
      s1_sat_in   = hsvr_pkg::clamp_in(sat);
      s1_val_in   = hsvr_pkg::clamp_in(val);
      s1_q60_prod = hue * hsvr_pkg::RECIP60;
      s1_q60_in   = s1_q60_prod[hsvr_pkg::RECIP60_SH +: 11];
      s1_vs_in    = s1_val_in * s1_sat_in;
   end

   always_comb begin
      s2_q60_x60     = 16'(s1_q60_ff * 6'd60);
      s2_within_in   = 6'(s1_hue_ff - s2_q60_x60);
      s2_q6_prod     = s1_q60_ff * hsvr_pkg::RECIP6;
      s2_q6_in       = s2_q6_prod[hsvr_pkg::RECIP6_SH +: 8];
      s2_chroma_prod = s1_vs_ff * hsvr_pkg::RECIP1000;
      s2_chroma_in   = s2_chroma_prod[hsvr_pkg::RECIP1000_SH +: LW];
   end

   always_comb begin
      s3_q6_x6     = 11'(s2_q6_ff * 3'd6);
      s3_sector_in = 3'(s2_q60_ff - s3_q6_x6);
      // odd sectors count down toward the next primary
      s3_dist      = s3_sector_in[0] ? (hsvr_pkg::SECTOR_DEG - 7'(s2_within_ff))
                                     : 7'(s2_within_ff);
      s3_cd_in     = 16'(s2_chroma_ff * s3_dist);
      s3_offset_in = (s2_chroma_ff <= s2_val_ff) ? (s2_val_ff - s2_chroma_ff) : '0;
   end

   always_comb begin
      s4_second_prod = s3_cd_ff * hsvr_pkg::RECIP60;
      s4_second_in   = s4_second_prod[hsvr_pkg::RECIP60_SH +: LW];
   end

   always_comb begin
      case (s4_sector_ff)
         hsvr_pkg::SECT_RED_GRN: begin
            r_sel = s4_chroma_ff; g_sel = s4_second_ff; b_sel = '0;
         end
         hsvr_pkg::SECT_GRN_RED: begin
            r_sel = s4_second_ff; g_sel = s4_chroma_ff; b_sel = '0;
         end
         hsvr_pkg::SECT_GRN_BLU: begin
            r_sel = '0; g_sel = s4_chroma_ff; b_sel = s4_second_ff;
         end
         hsvr_pkg::SECT_BLU_GRN: begin
            r_sel = '0; g_sel = s4_second_ff; b_sel = s4_chroma_ff;
         end
         hsvr_pkg::SECT_BLU_RED: begin
            r_sel = s4_second_ff; g_sel = '0; b_sel = s4_chroma_ff;
         end
         default: begin
            r_sel = s4_chroma_ff; g_sel = '0; b_sel = s4_second_ff;
         end
      endcase
      s5_rgb_in.red   = hsvr_pkg::clamp_sum({1'b0, r_sel} + {1'b0, s4_offset_ff});
      s5_rgb_in.green = hsvr_pkg::clamp_sum({1'b0, g_sel} + {1'b0, s4_offset_ff});
      s5_rgb_in.blue  = hsvr_pkg::clamp_sum({1'b0, b_sel} + {1'b0, s4_offset_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_hue_ff    <= hue;
         s1_q60_ff    <= s1_q60_in;
         s1_val_ff    <= s1_val_in;
         s1_vs_ff     <= s1_vs_in;
         s2_within_ff <= s2_within_in;
         s2_q60_ff    <= s1_q60_ff;
         s2_q6_ff     <= s2_q6_in;
         s2_chroma_ff <= s2_chroma_in;
         s2_val_ff    <= s1_val_ff;
         s3_sector_ff <= s3_sector_in;
         s3_cd_ff     <= s3_cd_in;
         s3_chroma_ff <= s2_chroma_ff;
         s3_offset_ff <= s3_offset_in;
         s4_sector_ff <= s3_sector_ff;
         s4_chroma_ff <= s3_chroma_ff;
         s4_offset_ff <= s3_offset_ff;
         s4_second_ff <= s4_second_in;
         s5_rgb_ff    <= s5_rgb_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_rgb   = s5_rgb_ff;

endmodule
